### design/kha_pkg.sv
// Shared types and constants for the key hold action detector.
package kha_pkg;

  // Number of entry registers behind the configuration port.
  localparam int unsigned ENTRY_REGS = 4;

  // Configuration port geometry.
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned REG_IDX_W = 3;

  // Hold counter width and its saturation value.
  localparam int unsigned HOLD_W = 16;
  localparam logic [HOLD_W-1:0] HOLD_MAX = '1;

  // Width of the reported entry index.
  localparam int unsigned INDEX_W = 2;

  // Register indexes, word address divided by four.
  localparam logic [REG_IDX_W-1:0] REG_PRESSED_LEVEL = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ENTRY0 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ENTRY1 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ENTRY2 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ENTRY3 = 3'd4;

  // One entry word: valid, kind (release when set) and tick threshold.
  typedef struct packed {
    logic              valid;
    logic              release_kind;
    logic [HOLD_W-1:0] ticks;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

### design/kha_if.sv
// Valid/ready channel interfaces for key samples and action results.
interface kha_key_if;
  logic valid;
  logic ready;
  logic key_level;

  modport source (output valid, output key_level, input ready);
  modport sink (input valid, input key_level, output ready);
endinterface

interface kha_action_if;
  logic        valid;
  logic        ready;
  logic        action_fired;
  logic [1:0]  action_index;
  logic        stable_pressed;
  logic [15:0] hold_ticks;

  modport source (output valid, output action_fired, output action_index,
                  output stable_pressed, output hold_ticks, input ready);
  modport sink (input valid, input action_fired, input action_index,
                input stable_pressed, input hold_ticks, output ready);
endinterface

### design/kha_regs.sv
// APB-style configuration registers: pressed level and entry words.
module kha_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [kha_pkg::ADDR_W-1:0]  paddr,
  input  logic [kha_pkg::DATA_W-1:0]  pwdata,
  output logic [kha_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output logic                        pressed_level_o,
  output kha_pkg::entry_t             entries_o [kha_pkg::ENTRY_REGS]
);
  import kha_pkg::*;

  logic                 pressed_level_q;
  entry_t               entry_q [ENTRY_REGS];
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign pready = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en = psel && penable && pwrite;

  // Register writes; writes to unused indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_level_q <= 1'b0;
      for (int i = 0; i < ENTRY_REGS; i++) begin
        entry_q[i] <= '0;
      end
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PRESSED_LEVEL: pressed_level_q <= pwdata[0];
        REG_ENTRY0:        entry_q[0] <= pwdata[ENTRY_W-1:0];
        REG_ENTRY1:        entry_q[1] <= pwdata[ENTRY_W-1:0];
        REG_ENTRY2:        entry_q[2] <= pwdata[ENTRY_W-1:0];
        REG_ENTRY3:        entry_q[3] <= pwdata[ENTRY_W-1:0];
        default:           ;
      endcase
    end
  end

  // Read back the addressed register, zero for unused addresses.
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_PRESSED_LEVEL: prdata = {{(DATA_W-1){1'b0}}, pressed_level_q};
      REG_ENTRY0:        prdata = {{(DATA_W-ENTRY_W){1'b0}}, entry_q[0]};
      REG_ENTRY1:        prdata = {{(DATA_W-ENTRY_W){1'b0}}, entry_q[1]};
      REG_ENTRY2:        prdata = {{(DATA_W-ENTRY_W){1'b0}}, entry_q[2]};
      REG_ENTRY3:        prdata = {{(DATA_W-ENTRY_W){1'b0}}, entry_q[3]};
      default:           prdata = '0;
    endcase
  end

  assign pressed_level_o = pressed_level_q;
  assign entries_o = entry_q;

endmodule

### design/kha_match.sv
// Priority search over the entry words for a press or release match.
module kha_match #(
  parameter int unsigned ENTRY_COUNT = 4
) (
  input  kha_pkg::entry_t              entries_i [kha_pkg::ENTRY_REGS],
  input  logic                         release_kind_i,
  input  logic [kha_pkg::HOLD_W-1:0]   hold_i,
  output logic                         hit_o,
  output logic [kha_pkg::INDEX_W-1:0]  hit_index_o
);
  import kha_pkg::*;

  // Entries beyond the register file are never valid.
  localparam int unsigned SEARCH =
    (ENTRY_COUNT < ENTRY_REGS) ? ENTRY_COUNT : ENTRY_REGS;

  // Walk from the highest index down so the lowest matching entry wins.
  always_comb begin
    hit_o = 1'b0;
    hit_index_o = '0;
    for (int i = SEARCH - 1; i >= 0; i--) begin
      if (entries_i[i].valid && (entries_i[i].release_kind == release_kind_i) &&
          (release_kind_i ? (entries_i[i].ticks <= hold_i)
                          : (entries_i[i].ticks == hold_i))) begin
        hit_o = 1'b1;
        hit_index_o = INDEX_W'(i);
      end
    end
  end

endmodule

### design/kha_core.sv
// Input register, debounce and hold state, entry match and result register.
module kha_core #(
  parameter int unsigned ENTRY_COUNT = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            pressed_level_i,
  input  kha_pkg::entry_t entries_i [kha_pkg::ENTRY_REGS],
  kha_key_if.sink         key_in,
  kha_action_if.source    act_out
);
  import kha_pkg::*;

  logic              in_valid_q;
  logic              in_key_q;
  logic              out_valid_q;
  logic              out_fired_q;
  logic [INDEX_W-1:0] out_index_q;
  logic              out_stable_q;
  logic [HOLD_W-1:0] out_hold_q;
  logic              prior_valid_q, prior_valid_d;
  logic              prior_level_q, prior_level_d;
  logic [HOLD_W-1:0] hold_q, hold_d;
  logic              advance;
  logic              in_ready;
  logic              debounced;
  logic              is_pressed;
  logic              fired;
  logic              stable;
  logic [HOLD_W-1:0] search_hold;
  logic              hit;
  logic [INDEX_W-1:0] hit_index;

  // The work stage moves when the result register is free or being drained.
  assign advance = !out_valid_q || act_out.ready;
  assign in_ready = !in_valid_q || advance;
  assign key_in.ready = in_ready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= key_in.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && key_in.valid) begin
      in_key_q <= key_in.key_level;
    end
  end

  assign debounced = prior_valid_q && (in_key_q == prior_level_q);
  assign is_pressed = (in_key_q == pressed_level_i);

  // Press entries compare against the stepped count, release against the hold.
  assign search_hold = is_pressed ? (hold_q + 1'b1) : hold_q;

  kha_match #(
    .ENTRY_COUNT (ENTRY_COUNT)
  ) u_match (
    .entries_i      (entries_i),
    .release_kind_i (!is_pressed),
    .hold_i         (search_hold),
    .hit_o          (hit),
    .hit_index_o    (hit_index)
  );

  // Debounce and hold counter update.
  always_comb begin
    prior_valid_d = prior_valid_q;
    prior_level_d = prior_level_q;
    hold_d = hold_q;
    fired = 1'b0;
    stable = 1'b0;
    if (!debounced) begin
      prior_valid_d = 1'b1;
      prior_level_d = in_key_q;
    end else if (is_pressed) begin
      stable = 1'b1;
      if (hold_q != HOLD_MAX) begin
        hold_d = hold_q + 1'b1;
        fired = hit;
      end
    end else begin
      fired = (hold_q != '0) && hit;
      hold_d = '0;
    end
  end

  // State and result valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_valid_q <= 1'b0;
      prior_level_q <= 1'b0;
      hold_q <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        prior_valid_q <= prior_valid_d;
        prior_level_q <= prior_level_d;
        hold_q <= hold_d;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      out_fired_q <= fired;
      out_index_q <= fired ? hit_index : '0;
      out_stable_q <= stable;
      out_hold_q <= hold_d;
    end
  end

  assign act_out.valid = out_valid_q;
  assign act_out.action_fired = out_fired_q;
  assign act_out.action_index = out_index_q;
  assign act_out.stable_pressed = out_stable_q;
  assign act_out.hold_ticks = out_hold_q;

endmodule

### design/key_hold_action_detector_top.sv
// Key hold action detector: sample register, one compute stage, result register.
// Path: the sample transfer loads the input register, and the result register loads
// from it while it is free or being drained, before the result transfer.
// Throughput: one sample per cycle while the result channel is not stalled, set by
// the single compute stage between the input register and the result register.
// Reset: asynchronous, active low; clears the debounce and hold state, the
// channel valids and all configuration registers.
module key_hold_action_detector_top #(
  parameter int unsigned ENTRY_COUNT = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [kha_pkg::ADDR_W-1:0]  paddr,
  input  logic [kha_pkg::DATA_W-1:0]  pwdata,
  output logic [kha_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  kha_key_if.sink                     key_in_i,
  kha_action_if.source                act_out_o
);
  import kha_pkg::*;

  logic   pressed_level;
  entry_t entries [ENTRY_REGS];

  kha_regs u_regs (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .pressed_level_o (pressed_level),
    .entries_o       (entries)
  );

  kha_core #(
    .ENTRY_COUNT (ENTRY_COUNT)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pressed_level_i (pressed_level),
    .entries_i       (entries),
    .key_in          (key_in_i),
    .act_out         (act_out_o)
  );

endmodule

### test/key_hold_action_detector_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the key hold action detector: queued key samples and action checks.
module key_hold_action_detector_top_test;
  import kha_pkg::*;

  // Register indexes that have no register behind them.
  localparam logic [REG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_LAST = 3'd7;

  // Sample to result latency of the block, and the length of the long receiver stall.
  localparam int unsigned PIPE_CYCLES = 2;
  localparam int unsigned SINK_HOLD_CYCLES = 400;
  localparam int unsigned SUB_PHASE_ITEMS = 125;

  // Directed key sequences, sent from the most significant bit down.
  localparam logic [12:0] DIRECTED_HIGH_KEYS = 13'b1111000101100;
  localparam logic [4:0]  DIRECTED_LOW_KEYS = 5'b00011;

  // One action result as the block reports it.
  typedef struct packed {
    logic               fired;
    logic [INDEX_W-1:0] index;
    logic               stable;
    logic [HOLD_W-1:0]  hold;
  } action_t;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  kha_key_if    key_if ();
  kha_action_if act_if ();

  key_hold_action_detector_top dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .key_in_i  (key_if),
    .act_out_o (act_if)
  );

  // Shadow copy of the configuration and the debounce and hold state.
  logic              shadow_pressed = 1'b0;
  entry_t            shadow_entry [ENTRY_REGS] = '{default: '0};
  logic              shadow_primed = 1'b0;
  logic              shadow_prior = 1'b0;
  logic [HOLD_W-1:0] shadow_hold = '0;

  action_t     expected_actions [$];
  logic        key_pending [$];
  bit          key_took = 1'b0;
  bit          sink_hold = 1'b0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned error_count = 0;

  // First valid entry of the wanted kind that matches the hold count, or -1.
  function automatic int find_entry(input logic want_release,
                                    input logic [HOLD_W-1:0] hold);
    for (int i = 0; i < ENTRY_REGS; i++) begin
      if (shadow_entry[i].valid && shadow_entry[i].release_kind == want_release &&
          (want_release ? (shadow_entry[i].ticks <= hold)
                        : (shadow_entry[i].ticks == hold)))
        return i;
    end
    return -1;
  endfunction

  // Advances the shadow state by one key sample and returns the action it causes.
  function automatic action_t predict_action(input logic key);
    action_t res;
    int      hit;
    res = '0;
    hit = -1;
    if (!shadow_primed || key != shadow_prior) begin
      shadow_prior = key;
      shadow_primed = 1'b1;
    end else if (key == shadow_pressed) begin
      res.stable = 1'b1;
      if (shadow_hold != HOLD_MAX) begin
        shadow_hold = shadow_hold + 1'b1;
        hit = find_entry(1'b0, shadow_hold);
      end
    end else begin
      if (shadow_hold != '0) hit = find_entry(1'b1, shadow_hold);
      shadow_hold = '0;
    end
    if (hit >= 0) begin
      res.fired = 1'b1;
      res.index = hit[INDEX_W-1:0];
    end
    res.hold = shadow_hold;
    return res;
  endfunction

  function automatic logic [DATA_W-1:0] entry_word(input logic v, input logic k,
                                                   input logic [HOLD_W-1:0] t);
    logic [DATA_W-1:0] w;
    w = $urandom;
    w[ENTRY_W-1:0] = {v, k, t};
    return w;
  endfunction

  // Entry words lean toward small thresholds so that entries actually fire.
  function automatic logic [DATA_W-1:0] random_entry_word();
    int unsigned       pick;
    logic [HOLD_W-1:0] t;
    pick = $urandom_range(9);
    if (pick < 7) t = HOLD_W'($urandom_range(12));
    else if (pick == 7) t = '0;
    else if (pick == 8) t = HOLD_MAX;
    else t = HOLD_W'($urandom);
    return entry_word($urandom_range(3) != 0, 1'($urandom_range(1)), t);
  endfunction

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Register write: a setup phase, then an access phase held until pready.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_PRESSED_LEVEL) shadow_pressed = data[0];
    else if (idx >= REG_ENTRY0 && idx <= REG_ENTRY3)
      shadow_entry[INDEX_W'(idx - REG_ENTRY0)] = data[ENTRY_W-1:0];
  endtask

  task automatic load_random_setting();
    write_reg(REG_PRESSED_LEVEL, $urandom);
    for (int i = 0; i < ENTRY_REGS; i++)
      write_reg(REG_IDX_W'(REG_ENTRY0 + i), random_entry_word());
    write_reg(REG_IDX_W'(REG_SPARE_FIRST + $urandom_range(REG_SPARE_LAST - REG_SPARE_FIRST)),
              $urandom);
  endtask

  // Mostly alternating press and release runs, with short bursts of bounce noise.
  task automatic queue_key_runs(input int unsigned count);
    int unsigned n;
    int unsigned len;
    logic        lvl;
    n = 0;
    lvl = shadow_pressed;
    @(posedge clk_i);
    while (n < count) begin
      if ($urandom_range(9) < 8) begin
        len = ($urandom_range(7) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
        repeat (len) key_pending.push_back(lvl);
        lvl = ~lvl;
      end else begin
        len = $urandom_range(4, 1);
        repeat (len) key_pending.push_back(1'($urandom_range(1)));
      end
      n += len;
    end
  endtask

  // Waits until every queued sample went through and every result came back.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (key_pending.size() != 0 || key_if.valid || expected_actions.size() != 0);
    repeat (PIPE_CYCLES + 2) @(negedge clk_i);
  endtask

  task automatic run_random_phase(input int unsigned src_pct, input int unsigned snk_pct,
                                  input bit sink_stall, input bit src_pause);
    load_random_setting();
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    if (sink_stall) begin
      fork
        begin
          @(posedge clk_i);
          sink_hold = 1'b1;
          repeat (SINK_HOLD_CYCLES) @(posedge clk_i);
          sink_hold = 1'b0;
        end
      join_none
    end
    queue_key_runs(SUB_PHASE_ITEMS / 2);
    if (src_pause) wait_drained();
    queue_key_runs(SUB_PHASE_ITEMS - SUB_PHASE_ITEMS / 2);
    wait_drained();
  endtask

  // Sample driver: holds an offered sample until its transfer, else offers the next one.
  always @(negedge clk_i) begin
    if (rst_ni && !(key_if.valid && !key_took)) begin
      if (key_pending.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        key_if.valid <= 1'b1;
        key_if.key_level <= key_pending[0];
      end else begin
        key_if.valid <= 1'b0;
        key_if.key_level <= 1'($urandom_range(1));
      end
    end
  end

  // Result receiver readiness.
  always @(negedge clk_i) begin
    if (rst_ni) act_if.ready <= !sink_hold && ($urandom_range(99) >= snk_idle_pct);
  end

  // Monitor: checks result transfers and predicts each sample transfer.
  always @(posedge clk_i) begin : action_monitor
    action_t got;
    action_t want;
    key_took = 1'b0;
    if (rst_ni) begin
      if (act_if.valid && act_if.ready) begin
        got = {act_if.action_fired, act_if.action_index, act_if.stable_pressed,
               act_if.hold_ticks};
        if (expected_actions.size() == 0) begin
          error_count++;
          $display({"%0t: unexpected result, expected none, ",
                    "actual fired=%0d index=%0d stable=%0d hold=%0d"},
                   $realtime, got.fired, got.index, got.stable, got.hold);
        end else begin
          want = expected_actions.pop_front();
          if (got.fired !== want.fired || got.index !== want.index ||
              got.stable !== want.stable || got.hold !== want.hold) begin
            error_count++;
            $display({"%0t: mismatch, expected fired=%0d index=%0d stable=%0d hold=%0d, ",
                      "actual fired=%0d index=%0d stable=%0d hold=%0d"},
                     $realtime, want.fired, want.index, want.stable, want.hold,
                     got.fired, got.index, got.stable, got.hold);
          end
        end
      end
      if (key_if.valid && key_if.ready) begin
        key_took = 1'b1;
        expected_actions.push_back(predict_action(key_if.key_level));
        if (key_pending.size() != 0) void'(key_pending.pop_front());
      end
    end
  end

  // Stimulus sequence.
  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    key_if.valid = 1'b0;
    key_if.key_level = 1'b0;
    act_if.ready = 1'b1;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: press entry at two ticks, a zero press threshold, two release thresholds.
    write_reg(REG_PRESSED_LEVEL, 32'd1);
    write_reg(REG_ENTRY0, entry_word(1'b1, 1'b0, 16'd2));
    write_reg(REG_ENTRY1, entry_word(1'b1, 1'b0, 16'd0));
    write_reg(REG_ENTRY2, entry_word(1'b1, 1'b1, 16'd3));
    write_reg(REG_ENTRY3, entry_word(1'b1, 1'b1, 16'd1));
    write_reg(REG_SPARE_LAST, 32'hFFFF_FFFF);
    @(posedge clk_i);
    // Priming, hold and fire, level change, release after hold, release without hold,
    // bounce, then a short hold released onto the last entry.
    for (int i = 12; i >= 0; i--) key_pending.push_back(DIRECTED_HIGH_KEYS[i]);
    wait_drained();
    // Same entries with the low level counting as pressed.
    write_reg(REG_PRESSED_LEVEL, 32'hFFFF_FFFE);
    @(posedge clk_i);
    for (int i = 4; i >= 0; i--) key_pending.push_back(DIRECTED_LOW_KEYS[i]);
    wait_drained();

    // Random part: sender mostly busy, receiver mostly stalled, with one sender pause.
    for (int p = 0; p < 4; p++) run_random_phase(13, 77, 1'b0, p == 1);
    // Sender mostly idle, receiver mostly ready, with one long receiver stall.
    for (int p = 0; p < 4; p++) run_random_phase(77, 13, p == 2, 1'b0);
    // No idling on either side, with another long receiver stall.
    for (int p = 0; p < 4; p++) run_random_phase(0, 0, p == 0, p == 3);

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
